// ===== rtl/fra_pkg.sv =====
// Shared constants, register codes and control structs of the Farey approximation unit.
package fra_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DEN_BITS_DEF  = 16;

  localparam int EPS_RESET     = 66;
  localparam int MAX_DEN_RESET = 255;

  localparam int CFG_INDEX_W   = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_EPSILON = 1'b0,
    REG_MAX_DEN = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic load;
    logic sum;
    logic step;
    logic decide;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic walk_on;
    logic accept;
  } status_t;

endpackage

// ===== rtl/fra_datapath.sv =====
// Mediant bounds, running products and the shared add and compare unit.
module fra_datapath #(
  parameter int FRAC_BITS = fra_pkg::FRAC_BITS_DEF,
  parameter int DEN_BITS  = fra_pkg::DEN_BITS_DEF
) (
  input  logic                 clk,
  input  fra_pkg::cmd_t        cmd,
  input  logic [FRAC_BITS:0]   value_x,
  input  logic [FRAC_BITS-1:0] epsilon,
  input  logic [DEN_BITS-1:0]  max_den,
  output fra_pkg::status_t     status,
  output logic [DEN_BITS-1:0]  res_num,
  output logic [DEN_BITS-1:0]  res_den
);

  localparam int BW = DEN_BITS + 1;
  localparam int PW = FRAC_BITS + DEN_BITS + 1;

  logic [BW-1:0] lower_num, lower_den, upper_num, upper_den;
  logic [PW-1:0] x_lower, x_upper, e_lower, e_upper;
  logic [BW-1:0] med_num, med_den;
  logic [PW-1:0] lhs, tol;
  logic [PW-1:0] rhs, diff;
  logic [BW-1:0] lim;
  logic          above;

  assign lim   = {1'b0, max_den};
  assign rhs   = {med_num, {FRAC_BITS{1'b0}}};
  assign above = rhs < lhs;
  assign diff  = above ? (lhs - rhs) : (rhs - lhs);

  assign status.walk_on = (lower_den <= lim) && (upper_den <= lim);
  assign status.accept  = diff < tol;

  always_comb begin
    if (cmd.decide) begin
      if (med_den <= lim) begin
        res_num = med_num[DEN_BITS-1:0];
        res_den = med_den[DEN_BITS-1:0];
      end else if (upper_den > lower_den) begin
        res_num = upper_num[DEN_BITS-1:0];
        res_den = upper_den[DEN_BITS-1:0];
      end else begin
        res_num = lower_num[DEN_BITS-1:0];
        res_den = lower_den[DEN_BITS-1:0];
      end
    end else if (lower_den > lim) begin
      res_num = upper_num[DEN_BITS-1:0];
      res_den = upper_den[DEN_BITS-1:0];
    end else begin
      res_num = lower_num[DEN_BITS-1:0];
      res_den = lower_den[DEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lower_num <= '0;
      lower_den <= {{(BW-1){1'b0}}, 1'b1};
      upper_num <= {{(BW-1){1'b0}}, 1'b1};
      upper_den <= {{(BW-1){1'b0}}, 1'b1};
      x_lower   <= {{(PW-FRAC_BITS-1){1'b0}}, value_x};
      x_upper   <= {{(PW-FRAC_BITS-1){1'b0}}, value_x};
      e_lower   <= {{(PW-FRAC_BITS){1'b0}}, epsilon};
      e_upper   <= {{(PW-FRAC_BITS){1'b0}}, epsilon};
    end else if (cmd.step) begin
      if (above) begin
        lower_num <= med_num;
        lower_den <= med_den;
        x_lower   <= lhs;
        e_lower   <= tol;
      end else begin
        upper_num <= med_num;
        upper_den <= med_den;
        x_upper   <= lhs;
        e_upper   <= tol;
      end
    end
    if (cmd.sum) begin
      med_num <= lower_num + upper_num;
      med_den <= lower_den + upper_den;
      lhs     <= x_lower + x_upper;
      tol     <= e_lower + e_upper;
    end
  end

endmodule

// ===== rtl/fra_ctrl.sv =====
// Sequencer of the mediant walk: load, sum, decide, step, capture.
module fra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_free,
  input  fra_pkg::status_t  status,
  output fra_pkg::cmd_t     cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SUM    = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t state, state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (status.walk_on) begin
          cmd.sum    = 1'b1;
          state_next = ST_DECIDE;
        end else if (out_free) begin
          cmd.capture = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (status.accept) begin
          if (out_free) begin
            cmd.capture = 1'b1;
            state_next  = ST_IDLE;
          end
        end else begin
          cmd.step   = 1'b1;
          state_next = ST_SUM;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/farey_rational_approximation_unit.sv =====
// Top level of the Farey best rational approximation unit.
// Each item x in [0,2) (FRAC_BITS fraction bits) is approximated by a Stern-Brocot
// mediant walk from 0/1 and 1/1; products are kept as running sums, so one add and
// compare unit does each step. An item whose walk forms k mediants spends one sum
// state and one decide state on each; its result goes into the output register in
// the decide state when the last mediant is accepted, and in the sum state once the
// walk stops at the denominator limit; a stalled output holds the capture back.
// k never exceeds twice max_denominator, is about max_denominator for a value near
// zero or at one and above, and is typically a few tens. A new item is taken once the
// previous walk has finished, while its result may still wait in the output register.
module farey_rational_approximation_unit #(
  parameter int FRAC_BITS = fra_pkg::FRAC_BITS_DEF,
  parameter int DEN_BITS  = fra_pkg::DEN_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [FRAC_BITS:0]                         value_x,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic [DEN_BITS-1:0]                        numerator,
  output logic [DEN_BITS-1:0]                        denominator,
  input  logic                                       cfg_write,
  input  logic [fra_pkg::CFG_INDEX_W-1:0]            cfg_index,
  input  logic [(FRAC_BITS > DEN_BITS ? FRAC_BITS : DEN_BITS)-1:0] cfg_data
);

  logic [FRAC_BITS-1:0] epsilon;
  logic [DEN_BITS-1:0]  max_den;
  fra_pkg::cmd_t        cmd;
  fra_pkg::status_t     status;
  logic [DEN_BITS-1:0]  res_num, res_den;
  logic                 out_free;
  logic                 busy;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= FRAC_BITS'(fra_pkg::EPS_RESET);
      max_den <= DEN_BITS'(fra_pkg::MAX_DEN_RESET);
    end else if (cfg_write) begin
      case (fra_pkg::reg_index_t'(cfg_index))
        fra_pkg::REG_EPSILON: epsilon <= cfg_data[FRAC_BITS-1:0];
        fra_pkg::REG_MAX_DEN: max_den <= cfg_data[DEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  fra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  fra_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .DEN_BITS  (DEN_BITS)
  ) u_datapath (
    .clk     (clk),
    .cmd     (cmd),
    .value_x (value_x),
    .epsilon (epsilon),
    .max_den (max_den),
    .status  (status),
    .res_num (res_num),
    .res_den (res_den)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      numerator   <= res_num;
      denominator <= res_den;
    end
  end

endmodule

// ===== rtl/fra_checker.sv =====
// Port-level checks of the Farey approximation unit and their bind.
module fra_checker #(
  parameter int FRAC_BITS = fra_pkg::FRAC_BITS_DEF,
  parameter int DEN_BITS  = fra_pkg::DEN_BITS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic [FRAC_BITS:0]  value_x,
  input logic                out_valid,
  input logic                out_stall,
  input logic [DEN_BITS-1:0] numerator,
  input logic [DEN_BITS-1:0] denominator
);

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(value_x))
    else $error("stalled input item changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(numerator) && $stable(denominator))
    else $error("held result item changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous walk still running");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> denominator != '0)
    else $error("zero denominator in result item");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> numerator <= denominator)
    else $error("numerator above denominator in result item");

endmodule

bind farey_rational_approximation_unit fra_checker #(
  .FRAC_BITS (FRAC_BITS),
  .DEN_BITS  (DEN_BITS)
) u_fra_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .value_x     (value_x),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .numerator   (numerator),
  .denominator (denominator)
);

// ===== verif/tb_farey_rational_approximation_unit.sv =====
// Self-checking testbench for the Farey rational approximation unit with a scoreboard predictor.
`timescale 1ns / 1ps

module tb_farey_rational_approximation_unit;

  localparam int XW = fra_pkg::FRAC_BITS_DEF + 1;
  localparam int DW = fra_pkg::DEN_BITS_DEF;
  localparam int BW = fra_pkg::DEN_BITS_DEF + 1;
  localparam int CW = fra_pkg::FRAC_BITS_DEF > fra_pkg::DEN_BITS_DEF ?
                      fra_pkg::FRAC_BITS_DEF : fra_pkg::DEN_BITS_DEF;
  localparam int HOLD_CYCLES = 400;

  typedef logic [XW-1:0] xval_t;

  typedef struct packed {
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } fraction_t;

  class approx_scoreboard;
    logic [fra_pkg::FRAC_BITS_DEF-1:0] eps_q16;
    logic [DW-1:0] den_limit;
    fraction_t expected_fracs[$];
    int failures;

    function new();
      eps_q16 = fra_pkg::FRAC_BITS_DEF'(fra_pkg::EPS_RESET);
      den_limit = DW'(fra_pkg::MAX_DEN_RESET);
      failures = 0;
    endfunction

    function void set_register(fra_pkg::reg_index_t idx, logic [CW-1:0] data);
      if (idx == fra_pkg::REG_EPSILON) eps_q16 = data[fra_pkg::FRAC_BITS_DEF-1:0];
      else den_limit = data[DW-1:0];
    endfunction

    function fraction_t best_fraction(xval_t x);
      logic [BW-1:0] lo_n, lo_d, up_n, up_d, med_n, med_d;
      logic [63:0] lhs, rhs, tol, diff;
      logic above, hit;
      fraction_t f;
      lo_n = '0; lo_d = BW'(1); up_n = BW'(1); up_d = BW'(1);
      f.num = '0; f.den = DW'(1);
      hit = 1'b0;
      while (!hit && lo_d <= den_limit && up_d <= den_limit) begin
        med_n = lo_n + up_n;
        med_d = lo_d + up_d;
        lhs = 64'(x) * 64'(med_d);
        rhs = 64'(med_n) << fra_pkg::FRAC_BITS_DEF;
        tol = 64'(eps_q16) * 64'(med_d);
        above = rhs < lhs;
        diff = above ? lhs - rhs : rhs - lhs;
        if (diff < tol) begin
          hit = 1'b1;
          if (med_d <= den_limit) begin
            f.num = DW'(med_n); f.den = DW'(med_d);
          end else if (up_d > lo_d) begin
            f.num = DW'(up_n); f.den = DW'(up_d);
          end else begin
            f.num = DW'(lo_n); f.den = DW'(lo_d);
          end
        end else if (above) begin
          lo_n = med_n; lo_d = med_d;
        end else begin
          up_n = med_n; up_d = med_d;
        end
      end
      if (!hit) begin
        if (lo_d > den_limit) begin
          f.num = DW'(up_n); f.den = DW'(up_d);
        end else begin
          f.num = DW'(lo_n); f.den = DW'(lo_d);
        end
      end
      return f;
    endfunction

    function void note_value(xval_t x);
      expected_fracs = {expected_fracs, best_fraction(x)};
    endfunction

    function void check_fraction(logic [DW-1:0] num, logic [DW-1:0] den);
      fraction_t exp_f;
      if (expected_fracs.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d", $time, num, den);
        failures++;
        return;
      end
      exp_f = expected_fracs.pop_front();
      if (num !== exp_f.num) begin
        $display("%0t: numerator expected %0d actual %0d", $time, exp_f.num, num);
        failures++;
      end
      if (den !== exp_f.den) begin
        $display("%0t: denominator expected %0d actual %0d", $time, exp_f.den, den);
        failures++;
      end
    endfunction

    function int pending();
      return expected_fracs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  xval_t value_x = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DW-1:0] numerator;
  logic [DW-1:0] denominator;
  logic cfg_write = 1'b0;
  fra_pkg::reg_index_t cfg_index = fra_pkg::REG_EPSILON;
  logic [CW-1:0] cfg_data = '0;

  bit quiet = 1'b0;
  bit hold_pending = 1'b0;
  int hold_left = 0;

  approx_scoreboard sb = new();

  farey_rational_approximation_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value_x(value_x),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .numerator(numerator),
    .denominator(denominator),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5s;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_pending) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_pending <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 19);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_value(value_x);
      if (out_valid && !out_stall) sb.check_fraction(numerator, denominator);
    end
  end

  task automatic push_value(input xval_t x);
    if (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    value_x <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CW-1:0] eps, input logic [CW-1:0] lim);
    cfg_write <= 1'b1;
    cfg_index <= fra_pkg::REG_EPSILON;
    cfg_data <= eps;
    @(posedge clk);
    cfg_index <= fra_pkg::REG_MAX_DEN;
    cfg_data <= lim;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_register(fra_pkg::REG_EPSILON, eps);
    sb.set_register(fra_pkg::REG_MAX_DEN, lim);
  endtask

  task automatic directed(input logic [CW-1:0] eps, input logic [CW-1:0] lim,
                          input xval_t vals[$]);
    wait_drained();
    set_limits(eps, lim);
    foreach (vals[i]) push_value(vals[i]);
  endtask

  function automatic xval_t pick_value(bit full_span);
    int r;
    r = $urandom_range(99);
    if (!full_span) return xval_t'($urandom_range(0, 65536));
    if (r < 5) return xval_t'($urandom_range(65537, 131071));
    if (r < 10) begin
      case ($urandom_range(3))
        0: return xval_t'(0);
        1: return xval_t'(65536);
        2: return xval_t'($urandom_range(1, 16));
        default: return xval_t'(65536 - $urandom_range(1, 16));
      endcase
    end
    return xval_t'($urandom_range(0, 65536));
  endfunction

  initial begin
    xval_t reset_vals[$];
    logic [CW-1:0] eps, lim;
    bit full_span;
    reset_vals = '{0, 65536, 1, 65535, 32768, 21845, 43690, 65537, 131071, 12345};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings first, then the register extremes
    foreach (reset_vals[i]) push_value(reset_vals[i]);
    directed(CW'(0), CW'(1), '{0, 65536, 32768, 131071});
    directed(CW'(100), CW'(0), '{0, 40000});
    directed(CW'(65535), CW'(65535), '{0, 65536, 1, 131071, 32768});
    directed(CW'(4000), CW'(3), '{10000, 30000, 50000});
    directed(CW'(0), CW'(65535), '{0, 32768, 12345});

    for (int p = 0; p < 6; p++) begin
      full_span = 1'b1;
      case (p)
        0: begin
          eps = CW'($urandom_range(0, 200)); lim = CW'($urandom_range(1, 255));
        end
        1: begin
          eps = '0; lim = CW'($urandom_range(1, 300));
        end
        2: begin
          eps = CW'($urandom_range(0, 65535)); lim = CW'($urandom_range(0, 40));
        end
        3: begin
          eps = CW'($urandom_range(1, 100)); lim = CW'(65535); full_span = 1'b0;
        end
        4: begin
          eps = CW'($urandom_range(0, 3000)); lim = CW'($urandom_range(1, 1000));
        end
        default: begin
          eps = CW'(fra_pkg::EPS_RESET); lim = CW'(fra_pkg::MAX_DEN_RESET);
        end
      endcase
      wait_drained();
      set_limits(eps, lim);
      for (int i = 0; i < 300; i++) begin
        if (p == 0 && i == 40) hold_pending <= 1'b1;
        if (p == 0 && i == 150) wait_drained();
        if (p == 1) quiet = (i >= 100 && i < 220);
        push_value(pick_value(full_span));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== farey_rational_approximation_unit.f =====
rtl/fra_pkg.sv
rtl/fra_datapath.sv
rtl/fra_ctrl.sv
rtl/farey_rational_approximation_unit.sv
rtl/fra_checker.sv
verif/tb_farey_rational_approximation_unit.sv
